/* src/mlbc_pkg.sv */
// shared constants and types for the multi-channel led blink controller
// no dependencies

package mlbc_pkg;

	// default number of led channels
	localparam int LED_COUNT_DEF = 8;

	// leds visible on the output pins
	localparam int LED_OUT_W = 8;

	// command codes of one input request
	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_SET  = 1'b1
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_PULSE = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	// configuration register indexes
	typedef enum logic {
		CFG_ACTIVE_HIGH = 1'b0,
		CFG_LEDS_IN_USE = 1'b1
	} cfg_idx_t;

endpackage

/* src/multi_led_blink_controller_unit.sv */
// multi-channel led blink controller: input register, per-led update logic, result register
// depends on mlbc_pkg
// an accepted request moves through the input register and the per-led update logic into the output register
// throughput: one request per cycle while results are taken, all led channels tick in parallel
// the state update of one request lands before the next request reaches the logic
// reset: arst_n clears all leds dark, no blink running, mask all active high, no leds in use

module multi_led_blink_controller_unit
	import mlbc_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [2:0]  led_index,
	input  logic [15:0] period,
	input  logic [15:0] pulse,
	input  logic [23:0] time_limit,
	input  logic [15:0] count_limit,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  led_levels,
	output logic [7:0]  blinking,
	output logic [1:0]  status,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	// configuration registers
	logic [7:0] active_high_q;
	logic [3:0] leds_in_use_q;

	// input stage
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [2:0]  idx_s1;
	logic [15:0] period_s1;
	logic [15:0] pulse_s1;
	logic [23:0] time_s1;
	logic [15:0] count_s1;

	// result stage
	logic    out_valid_q;
	logic [7:0] levels_q;
	logic [7:0] blinking_q;
	status_t status_q;

	// per-led state
	logic        lit_q     [LED_COUNT];
	logic        run_q     [LED_COUNT];
	logic [15:0] bperiod_q [LED_COUNT];
	logic [15:0] bpulse_q  [LED_COUNT];
	logic [23:0] tbound_q  [LED_COUNT];
	logic [15:0] cbound_q  [LED_COUNT];
	logic [15:0] phase_q   [LED_COUNT];
	logic [16:0] cycles_q  [LED_COUNT];
	logic [24:0] elapsed_q [LED_COUNT];

	logic        lit_d     [LED_COUNT];
	logic        run_d     [LED_COUNT];
	logic [15:0] bperiod_d [LED_COUNT];
	logic [15:0] bpulse_d  [LED_COUNT];
	logic [23:0] tbound_d  [LED_COUNT];
	logic [15:0] cbound_d  [LED_COUNT];
	logic [15:0] phase_d   [LED_COUNT];
	logic [16:0] cycles_d  [LED_COUNT];
	logic [24:0] elapsed_d [LED_COUNT];

	logic    advance;
	logic    idx_known;
	status_t status_d;
	logic [7:0] levels_d;
	logic [7:0] blinking_d;

	// handshakes
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid  = out_valid_q;
	assign led_levels = levels_q;
	assign blinking   = blinking_q;
	assign status     = status_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 8'hFF;
			leds_in_use_q <= 4'd0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ACTIVE_HIGH: active_high_q <= cfg_data;
				CFG_LEDS_IN_USE: leds_in_use_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= cmd_t'(command);
			idx_s1    <= led_index;
			period_s1 <= period;
			pulse_s1  <= pulse;
			time_s1   <= time_limit;
			count_s1  <= count_limit;
		end
	end

	// addressed led must be registered and exist
	assign idx_known = ({1'b0, idx_s1} < leds_in_use_q) && (32'(idx_s1) < LED_COUNT);

	// status of the request in the input stage
	always_comb begin
		status_d = ST_OK;
		if (cmd_s1 == CMD_SET) begin
			if (!idx_known) begin
				status_d = ST_BAD_INDEX;
			end else if (pulse_s1 > period_s1) begin
				status_d = ST_BAD_PULSE;
			end
		end
	end

	// per-led next state
	always_comb begin
		for (int i = 0; i < LED_COUNT; i++) begin
			logic [15:0] ph_inc;
			ph_inc       = phase_q[i] + 16'd1;
			lit_d[i]     = lit_q[i];
			run_d[i]     = run_q[i];
			bperiod_d[i] = bperiod_q[i];
			bpulse_d[i]  = bpulse_q[i];
			tbound_d[i]  = tbound_q[i];
			cbound_d[i]  = cbound_q[i];
			phase_d[i]   = phase_q[i];
			cycles_d[i]  = cycles_q[i];
			elapsed_d[i] = elapsed_q[i];
			if (cmd_s1 == CMD_TICK) begin
				// one tick of a running blink
				if (run_q[i]) begin
					phase_d[i] = ph_inc;
					if (ph_inc == bpulse_q[i]) begin
						lit_d[i] = 1'b0;
					end
					if (ph_inc == bperiod_q[i]) begin
						phase_d[i] = 16'd0;
						if (cbound_q[i] != 16'd0) begin
							cycles_d[i] = cycles_q[i] + 17'd1;
						end
						if (tbound_q[i] != 24'd0) begin
							elapsed_d[i] = elapsed_q[i] + {9'd0, bperiod_q[i]};
						end
						if (cycles_d[i] <= {1'b0, cbound_q[i]}
						    && elapsed_d[i] <= {1'b0, tbound_q[i]}) begin
							lit_d[i] = 1'b1;
						end else begin
							run_d[i] = 1'b0;
						end
					end
				end
			end else if (idx_known && 32'(idx_s1) == i) begin
				// set mode on this led: store values, stop any blink, then start a new one if pulse lies between zero and period
				bperiod_d[i] = period_s1;
				bpulse_d[i]  = pulse_s1;
				tbound_d[i]  = time_s1;
				cbound_d[i]  = count_s1;
				run_d[i]     = 1'b0;
				if (pulse_s1 > period_s1) begin
					lit_d[i] = lit_q[i];
				end else if (period_s1 == 16'd0) begin
					lit_d[i] = !lit_q[i];
				end else if (pulse_s1 == 16'd0) begin
					lit_d[i] = 1'b0;
				end else if (pulse_s1 == period_s1) begin
					lit_d[i] = 1'b1;
				end else begin
					run_d[i]     = 1'b1;
					lit_d[i]     = 1'b1;
					phase_d[i]   = 16'd0;
					cycles_d[i]  = 17'd0;
					elapsed_d[i] = 25'd0;
				end
			end
		end
	end

	// pin levels and blink flags after the update
	always_comb begin
		levels_d   = '0;
		blinking_d = '0;
		for (int i = 0; i < LED_OUT_W; i++) begin
			if (i < LED_COUNT) begin
				levels_d[i]   = active_high_q[i] ? lit_d[i] : !lit_d[i];
				blinking_d[i] = run_d[i];
			end
		end
	end

	// per-led control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				lit_q[i] <= 1'b0;
				run_q[i] <= 1'b0;
			end
		end else if (advance) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				lit_q[i] <= lit_d[i];
				run_q[i] <= run_d[i];
			end
		end
	end

	// per-led blink settings and counters
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				bperiod_q[i] <= bperiod_d[i];
				bpulse_q[i]  <= bpulse_d[i];
				tbound_q[i]  <= tbound_d[i];
				cbound_q[i]  <= cbound_d[i];
				phase_q[i]   <= phase_d[i];
				cycles_q[i]  <= cycles_d[i];
				elapsed_q[i] <= elapsed_d[i];
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			levels_q   <= levels_d;
			blinking_q <= blinking_d;
			status_q   <= status_d;
		end
	end

endmodule

/* test/multi_led_blink_controller_unit_test.sv */
// self-checking testbench for the multi-channel led blink controller
// depends on mlbc_pkg and multi_led_blink_controller_unit; a directed table, then random phases
// every result is checked against a cycle-free prediction of the led state, or against the row's own result

module multi_led_blink_controller_unit_test;
	import mlbc_pkg::*;

	localparam int LEDS            = LED_COUNT_DEF;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 63;

	// one input request and one result
	typedef struct {
		cmd_t        cmd;
		logic [2:0]  idx;
		logic [15:0] per;
		logic [15:0] pul;
		logic [23:0] tl;
		logic [15:0] cl;
	} blink_req_t;

	typedef struct {
		logic [7:0] levels;
		logic [7:0] blinking;
		status_t    status;
	} blink_res_t;

	// one row of the directed table: a register write or a request
	typedef struct {
		bit         is_cfg;
		cfg_idx_t   sel;
		logic [7:0] val;
		blink_req_t req;
		bit         typed;
		blink_res_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [2:0]  led_index;
	logic [15:0] period;
	logic [15:0] pulse;
	logic [23:0] time_limit;
	logic [15:0] count_limit;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  led_levels;
	logic [7:0]  blinking;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	// predicted led state and configuration
	logic [7:0]  mask_cfg;
	logic [3:0]  leds_used_cfg;
	logic        lit_now     [LEDS];
	logic        blink_on    [LEDS];
	logic [15:0] set_period  [LEDS];
	logic [15:0] set_pulse   [LEDS];
	logic [23:0] bound_time  [LEDS];
	logic [15:0] bound_count [LEDS];
	logic [15:0] tick_phase  [LEDS];
	logic [16:0] cycle_cnt   [LEDS];
	logic [24:0] elapsed_cnt [LEDS];

	blink_res_t results_due[$];
	blink_res_t due_res;
	stim_row_t  plan[$];
	int         errors;
	int         stall_cycles;
	int         hold_left;
	bit         hold_req;
	bit         idle_en;

	multi_led_blink_controller_unit #(
		.LED_COUNT(LEDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.led_index(led_index),
		.period(period),
		.pulse(pulse),
		.time_limit(time_limit),
		.count_limit(count_limit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_levels(led_levels),
		.blinking(blinking),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// advance the led state by one request and return the pins it leaves
	function automatic blink_res_t predict_leds(blink_req_t r);
		blink_res_t res;
		res.status = ST_OK;
		if (r.cmd == CMD_TICK) begin
			for (int i = 0; i < LEDS; i++) begin
				if (blink_on[i]) begin
					tick_phase[i] = tick_phase[i] + 16'd1;
					if (tick_phase[i] == set_pulse[i])
						lit_now[i] = 1'b0;
					if (tick_phase[i] == set_period[i]) begin
						tick_phase[i] = '0;
						if (bound_count[i] != 0)
							cycle_cnt[i] = cycle_cnt[i] + 17'd1;
						if (bound_time[i] != 0)
							elapsed_cnt[i] = elapsed_cnt[i] + 25'(set_period[i]);
						if (cycle_cnt[i] <= 17'(bound_count[i]) &&
						    elapsed_cnt[i] <= 25'(bound_time[i]))
							lit_now[i] = 1'b1;
						else
							blink_on[i] = 1'b0;
					end
				end
			end
		end else if (4'(r.idx) >= leds_used_cfg || int'(r.idx) >= LEDS) begin
			res.status = ST_BAD_INDEX;
		end else begin
			// any set command stops the blink on that led first
			set_period[r.idx]  = r.per;
			set_pulse[r.idx]   = r.pul;
			bound_time[r.idx]  = r.tl;
			bound_count[r.idx] = r.cl;
			blink_on[r.idx]    = 1'b0;
			if (r.pul > r.per) begin
				res.status = ST_BAD_PULSE;
			end else if (r.per == 0) begin
				lit_now[r.idx] = ~lit_now[r.idx];
			end else if (r.pul == 0) begin
				lit_now[r.idx] = 1'b0;
			end else if (r.pul == r.per) begin
				lit_now[r.idx] = 1'b1;
			end else begin
				blink_on[r.idx]    = 1'b1;
				lit_now[r.idx]     = 1'b1;
				tick_phase[r.idx]  = '0;
				cycle_cnt[r.idx]   = '0;
				elapsed_cnt[r.idx] = '0;
			end
		end
		for (int i = 0; i < 8; i++) begin
			res.levels[i]   = mask_cfg[i] ? lit_now[i] : ~lit_now[i];
			res.blinking[i] = blink_on[i];
		end
		return res;
	endfunction

	// directed rows
	function automatic stim_row_t chk_row(cmd_t c, int idx, int per, int pul, int tl, int cl,
	                                      logic [7:0] lv, logic [7:0] bl, status_t st);
		stim_row_t row;
		row.is_cfg       = 1'b0;
		row.sel          = CFG_ACTIVE_HIGH;
		row.val          = '0;
		row.req.cmd      = c;
		row.req.idx      = idx[2:0];
		row.req.per      = per[15:0];
		row.req.pul      = pul[15:0];
		row.req.tl       = tl[23:0];
		row.req.cl       = cl[15:0];
		row.typed        = 1'b1;
		row.res.levels   = lv;
		row.res.blinking = bl;
		row.res.status   = st;
		return row;
	endfunction

	function automatic stim_row_t req_row(cmd_t c, int idx, int per, int pul, int tl, int cl);
		stim_row_t row;
		row       = chk_row(c, idx, per, pul, tl, cl, 8'h00, 8'h00, ST_OK);
		row.typed = 1'b0;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(cfg_idx_t sel, logic [7:0] val);
		stim_row_t row;
		row        = req_row(CMD_TICK, 0, 0, 0, 0, 0);
		row.is_cfg = 1'b1;
		row.sel    = sel;
		row.val    = val;
		return row;
	endfunction

	// random request: mostly ticks, set commands biased to short blinks and every special case
	function automatic blink_req_t rand_request();
		blink_req_t r;
		int pick;
		int p;
		r.cmd = CMD_TICK;
		r.idx = 3'($urandom);
		r.per = 16'($urandom);
		r.pul = 16'($urandom);
		r.tl  = 24'($urandom);
		r.cl  = 16'($urandom);
		if ($urandom_range(99) < 28) begin
			r.cmd = CMD_SET;
			pick  = $urandom_range(99);
			if (pick < 55) begin
				p     = $urandom_range(8, 2);
				r.per = 16'(p);
				r.pul = 16'($urandom_range(p - 1, 1));
			end else if (pick < 62) begin
				r.per = '0;
				r.pul = '0;
			end else if (pick < 70) begin
				r.per = 16'($urandom_range(8, 1));
				r.pul = '0;
			end else if (pick < 78) begin
				r.pul = r.per;
			end else if (pick < 88) begin
				p     = $urandom_range(6, 0);
				r.per = 16'(p);
				r.pul = 16'(p + $urandom_range(4, 1));
			end
			pick = $urandom_range(99);
			if (pick < 50)
				r.tl = '0;
			else if (pick < 85)
				r.tl = 24'($urandom_range(30, 1));
			pick = $urandom_range(99);
			if (pick < 45)
				r.cl = '0;
			else if (pick < 85)
				r.cl = 16'($urandom_range(4, 1));
		end
		return r;
	endfunction

	// offer one request, hold it until accepted, then maybe idle
	task automatic offer_request(blink_req_t r, bit typed, blink_res_t typed_res);
		blink_res_t guess;
		in_valid    <= 1'b1;
		command     <= r.cmd;
		led_index   <= r.idx;
		period      <= r.per;
		pulse       <= r.pul;
		time_limit  <= r.tl;
		count_limit <= r.cl;
		do @(posedge clk); while (!in_ready);
		guess = predict_leds(r);
		if (typed)
			results_due.push_back(typed_res);
		else
			results_due.push_back(guess);
		if (idle_en && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (idle_en && $urandom_range(99) < 22);
		end
	endtask

	// stop offering and wait until the block has nothing left in flight
	task automatic settle_block();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, only while idle
	task automatic write_reg(cfg_idx_t sel, logic [7:0] val);
		settle_block();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (sel == CFG_ACTIVE_HIGH)
			mask_cfg = val;
		else
			leds_used_cfg = val[3:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result receiver with random stalls and one long hold-off
	initial begin
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_en && $urandom_range(99) < 22);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t ERROR unexpected result: levels %h blinking %h status %0d",
				         $time, led_levels, blinking, status);
				errors++;
			end else begin
				due_res = results_due.pop_front();
				if (led_levels !== due_res.levels) begin
					$display("%0t ERROR led_levels: expected %h, got %h",
					         $time, due_res.levels, led_levels);
					errors++;
				end
				if (blinking !== due_res.blinking) begin
					$display("%0t ERROR blinking: expected %h, got %h",
					         $time, due_res.blinking, blinking);
					errors++;
				end
				if (status !== due_res.status) begin
					$display("%0t ERROR status: expected %0d, got %0d",
					         $time, due_res.status, status);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving on any channel
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			    (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("ERROR watchdog expired at %0t", $time);
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus
	initial begin
		blink_res_t none;
		int ph;
		int n;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		command     <= CMD_TICK;
		led_index   <= '0;
		period      <= '0;
		pulse       <= '0;
		time_limit  <= '0;
		count_limit <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_ACTIVE_HIGH;
		cfg_data    <= '0;
		errors        = 0;
		hold_req      = 1'b0;
		idle_en       = 1'b1;
		none.levels   = '0;
		none.blinking = '0;
		none.status   = ST_OK;
		// state after reset
		mask_cfg      = 8'hff;
		leds_used_cfg = '0;
		for (int i = 0; i < LEDS; i++) begin
			lit_now[i]     = 1'b0;
			blink_on[i]    = 1'b0;
			set_period[i]  = '0;
			set_pulse[i]   = '0;
			bound_time[i]  = '0;
			bound_count[i] = '0;
			tick_phase[i]  = '0;
			cycle_cnt[i]   = '0;
			elapsed_cnt[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset values, bad index with no leds, inverted pins, all set cases
		plan.push_back(chk_row(CMD_TICK, 7, 16'hffff, 16'hffff, 24'hffffff, 16'hffff,
		                       8'h00, 8'h00, ST_OK));
		plan.push_back(chk_row(CMD_SET, 0, 10, 5, 0, 0, 8'h00, 8'h00, ST_BAD_INDEX));
		plan.push_back(cfg_row(CFG_LEDS_IN_USE, 8'd8));
		plan.push_back(cfg_row(CFG_ACTIVE_HIGH, 8'h00));
		plan.push_back(chk_row(CMD_TICK, 0, 0, 0, 0, 0, 8'hff, 8'h00, ST_OK));
		plan.push_back(chk_row(CMD_SET, 7, 0, 0, 0, 0, 8'h7f, 8'h00, ST_OK));
		plan.push_back(chk_row(CMD_SET, 7, 0, 0, 0, 0, 8'hff, 8'h00, ST_OK));
		plan.push_back(cfg_row(CFG_ACTIVE_HIGH, 8'hff));
		plan.push_back(chk_row(CMD_SET, 0, 5, 6, 0, 0, 8'h00, 8'h00, ST_BAD_PULSE));
		plan.push_back(chk_row(CMD_SET, 1, 16'hffff, 16'hffff, 24'hffffff, 16'hffff,
		                       8'h02, 8'h00, ST_OK));
		plan.push_back(chk_row(CMD_SET, 1, 16'hffff, 0, 0, 0, 8'h00, 8'h00, ST_OK));
		plan.push_back(chk_row(CMD_SET, 2, 3, 1, 0, 0, 8'h04, 8'h04, ST_OK));
		plan.push_back(chk_row(CMD_TICK, 0, 0, 0, 0, 0, 8'h00, 8'h04, ST_OK));
		plan.push_back(chk_row(CMD_TICK, 0, 0, 0, 0, 0, 8'h00, 8'h04, ST_OK));
		plan.push_back(chk_row(CMD_TICK, 0, 0, 0, 0, 0, 8'h04, 8'h04, ST_OK));
		// count bound of one: two blink periods then the blink ends
		plan.push_back(req_row(CMD_SET, 3, 2, 1, 0, 1));
		for (int k = 0; k < 6; k++)
			plan.push_back(req_row(CMD_TICK, 0, 0, 0, 0, 0));
		// time bound, interrupted blink, long blink at the extremes, toggle
		plan.push_back(req_row(CMD_SET, 4, 4, 2, 4, 0));
		plan.push_back(req_row(CMD_SET, 2, 1, 2, 0, 0));
		plan.push_back(req_row(CMD_SET, 5, 16'hffff, 1, 24'hffffff, 16'hffff));
		plan.push_back(req_row(CMD_SET, 6, 0, 0, 0, 0));
		// fewer leds in use: led 5 is rejected but keeps blinking
		plan.push_back(cfg_row(CFG_LEDS_IN_USE, 8'd3));
		plan.push_back(req_row(CMD_SET, 5, 4, 2, 0, 0));
		plan.push_back(req_row(CMD_TICK, 0, 0, 0, 0, 0));

		foreach (plan[k]) begin
			if (plan[k].is_cfg)
				write_reg(plan[k].sel, plan[k].val);
			else
				offer_request(plan[k].req, plan[k].typed, plan[k].res);
		end

		// random phases, each under its own register settings
		for (ph = 0; ph < PHASES; ph++) begin
			idle_en = (ph != 0);
			write_reg(CFG_ACTIVE_HIGH, (ph == 1) ? 8'h00 : (ph == 2) ? 8'hff : 8'($urandom));
			write_reg(CFG_LEDS_IN_USE, (ph == 3) ? 8'd0 : (ph % 2 == 1) ? 8'd8 :
			          8'($urandom_range(8, 1)));
			if (ph == 2)
				hold_req = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				offer_request(rand_request(), 1'b0, none);
		end

		settle_block();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
src/mlbc_pkg.sv
src/multi_led_blink_controller_unit.sv
test/multi_led_blink_controller_unit_test.sv
